// ----- src/assert_macros.svh -----
// Assertion macros for the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/rmst_pkg.sv -----
// Package for the message slot table: sizes, codes and shared types.
// No dependencies.
package rmst_pkg;
    localparam int REGIONS          = 4;
    localparam int SLOTS_PER_REGION = 16;
    localparam int BUF_BYTES        = 4096;
    localparam int THREAD_ID_BITS   = 16;
    localparam int NSLOTS           = REGIONS * SLOTS_PER_REGION;
    localparam int SLOT_BITS        = $clog2(NSLOTS);
    localparam int REG_BITS         = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int SPR_BITS         = (SLOTS_PER_REGION > 1) ? $clog2(SLOTS_PER_REGION) : 1;
    localparam int FREE_BITS        = $clog2(SLOTS_PER_REGION + 1);
    localparam int TOTAL_BITS       = $clog2(NSLOTS + 1);
    localparam int QDEPTH           = 2;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_ADDREF  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_FREE  = 2'd2,
        ST_NO_MSG   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC,
        BK_OUT
    } back_state_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t                 op;
        logic [15:0]         caller;
        logic [15:0]         peer;
        logic [15:0]         size;
        logic [31:0]         want;
        logic                size_bad;
    } cmd_t;
endpackage

// ----- src/refcounted_message_slot_table.sv -----
// An accepted word passes the front queue, then the back end's read, execute
// and output steps around the single slot memory port. The back end takes
// a new word only after the result word of the last one has been taken.
// A two-entry queue lets the front accept words while the back end works.
// rst_n is asynchronous; reset frees every slot and clears ids and counters.
module refcounted_message_slot_table
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // opcode[1:0], caller_thread[17:2], peer_thread[33:18], msg_size[49:34],
    // message_id[81:50], zero fill
    input  logic [87:0]     s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // status[1:0], region_index[3:2], slot_index[7:4], size_out[20:8],
    // assigned_id[52:21], message_flags[60:53], free_total[67:61],
    // send_count[131:68], receive_count[195:132], zero fill
    output logic [199:0]    m_axis_tdata
);
    logic           q_valid, q_ready;
    rmst_pkg::cmd_t q_cmd;
    logic [255:0]   res;

    rmst_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata[81:0]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    rmst_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = res[199:0];
endmodule

// ----- src/rmst_front.sv -----
// Front end: accepts words, masks thread ids and checks the send size.
// Depends on rmst_pkg.
module rmst_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [81:0]     in_data,
    output logic            q_valid,
    input  logic            q_ready,
    output rmst_pkg::cmd_t  q_cmd
);
    localparam logic [15:0] TMASK = 16'((17'd1 << rmst_pkg::THREAD_ID_BITS) - 17'd1);

    rmst_pkg::cmd_t                 mem_reg [rmst_pkg::QDEPTH];
    logic                           wp_reg, rp_reg;
    logic [1:0]                     cnt_reg;
    rmst_pkg::cmd_t                 cmd;
    logic                           push, pop;

    always_comb
    begin
        cmd.op       = rmst_pkg::op_t'(in_data[1:0]);
        cmd.caller   = in_data[17:2] & TMASK;
        cmd.peer     = in_data[33:18] & TMASK;
        cmd.size     = in_data[49:34];
        cmd.want     = in_data[81:50];
        cmd.size_bad = (in_data[49:34] == 16'd0) ||
                       (in_data[49:34] > 16'(rmst_pkg::BUF_BYTES));
    end

    assign in_ready = (cnt_reg != 2'(rmst_pkg::QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- src/rmst_back.sv -----
// Back end: slot table search, slot memory read-modify-write and result word.
// Depends on rmst_pkg.
module rmst_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  rmst_pkg::cmd_t  q_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [255:0]    out_data
);
    localparam int N = rmst_pkg::NSLOTS;
    localparam int SB = rmst_pkg::SLOT_BITS;

    // Search keys live in flops; sizes and counts live in memory.
    logic [N-1:0]           busy_reg;
    logic [15:0]            src_reg [N];
    logic [31:0]            ident_reg [N];
    logic [12:0]            len_mem [N];
    logic [7:0]             refs_mem [N];
    logic [31:0]            next_id_reg [rmst_pkg::REGIONS];
    logic [rmst_pkg::FREE_BITS-1:0] free_reg [rmst_pkg::REGIONS];
    logic [63:0]            sends_reg, recvs_reg;

    rmst_pkg::back_state_t  state_reg, state_next;
    rmst_pkg::cmd_t         cmd_reg;
    logic                   found_reg;
    logic [SB-1:0]          place_reg;
    logic [12:0]            rd_len_reg;
    logic [7:0]             rd_refs_reg;
    logic [255:0]           out_reg;

    logic [N-1:0]           hit;
    logic                   any_hit;
    logic [SB-1:0]          first;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            case (cmd_reg.op)
                rmst_pkg::OP_SEND:    hit[k] = !busy_reg[k];
                rmst_pkg::OP_RECEIVE: hit[k] = busy_reg[k] && (src_reg[k] == cmd_reg.peer);
                default:              hit[k] = (ident_reg[k] == cmd_reg.want);
            endcase
        end
        any_hit = |hit;
        first   = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                first = SB'(k);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_ready    = 1'b0;
        case (state_reg)
            rmst_pkg::BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    state_next = rmst_pkg::BK_READ;
                end
            end
            rmst_pkg::BK_READ: state_next = rmst_pkg::BK_EXEC;
            rmst_pkg::BK_EXEC: state_next = rmst_pkg::BK_OUT;
            rmst_pkg::BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = rmst_pkg::BK_IDLE;
                end
            end
            default: state_next = rmst_pkg::BK_IDLE;
        endcase
    end

    assign out_valid = (state_reg == rmst_pkg::BK_OUT);
    assign out_data  = out_reg;

    // Memory ports: one read in READ, one write in EXEC.
    always_ff @(posedge clk)
    begin
        if (state_reg == rmst_pkg::BK_IDLE && q_valid)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == rmst_pkg::BK_READ)
        begin
            found_reg   <= any_hit;
            place_reg   <= first;
            rd_len_reg  <= len_mem[first];
            rd_refs_reg <= refs_mem[first];
        end
        if (state_reg == rmst_pkg::BK_EXEC && found_reg)
        begin
            if (cmd_reg.op == rmst_pkg::OP_SEND && !cmd_reg.size_bad)
            begin
                len_mem[place_reg]  <= cmd_reg.size[12:0];
                refs_mem[place_reg] <= 8'd1;
            end
            else if (cmd_reg.op == rmst_pkg::OP_RECEIVE ||
                     (cmd_reg.op == rmst_pkg::OP_RELEASE && busy_reg[place_reg]))
            begin
                refs_mem[place_reg] <= (rd_refs_reg > 8'd1) ? rd_refs_reg - 8'd1 : 8'd0;
            end
            else if (cmd_reg.op == rmst_pkg::OP_ADDREF && busy_reg[place_reg])
            begin
                refs_mem[place_reg] <= (rd_refs_reg == 8'd255) ? 8'd255 : rd_refs_reg + 8'd1;
            end
        end
    end

    logic [rmst_pkg::REG_BITS-1:0] rgn;
    logic                          ok, do_send, do_recv, do_drop, frees;
    logic [1:0]                    st;
    logic [rmst_pkg::TOTAL_BITS-1:0] total;
    logic [63:0]                   sends_n, recvs_n;

    always_comb
    begin
        rgn     = rmst_pkg::REG_BITS'(place_reg / rmst_pkg::SLOTS_PER_REGION);
        do_send = (cmd_reg.op == rmst_pkg::OP_SEND) && !cmd_reg.size_bad && found_reg;
        do_recv = (cmd_reg.op == rmst_pkg::OP_RECEIVE) && found_reg;
        do_drop = do_recv || ((cmd_reg.op == rmst_pkg::OP_RELEASE) && found_reg
                              && busy_reg[place_reg]);
        frees   = do_drop && (rd_refs_reg <= 8'd1);
        case (cmd_reg.op)
            rmst_pkg::OP_SEND:
                st = cmd_reg.size_bad ? rmst_pkg::ST_INVALID :
                     (found_reg ? rmst_pkg::ST_OK : rmst_pkg::ST_NO_FREE);
            rmst_pkg::OP_RECEIVE:
                st = found_reg ? rmst_pkg::ST_OK : rmst_pkg::ST_NO_MSG;
            default:
                st = found_reg ? rmst_pkg::ST_OK : rmst_pkg::ST_INVALID;
        endcase
        ok      = (st == rmst_pkg::ST_OK);
        sends_n = sends_reg + 64'(do_send);
        recvs_n = recvs_reg + 64'(do_recv);
        total   = '0;
        for (int r = 0; r < rmst_pkg::REGIONS; r++)
        begin
            total = total + rmst_pkg::TOTAL_BITS'(free_reg[r])
                  - rmst_pkg::TOTAL_BITS'(do_send && rgn == rmst_pkg::REG_BITS'(r))
                  + rmst_pkg::TOTAL_BITS'(frees && rgn == rmst_pkg::REG_BITS'(r));
        end
    end

    // Result word, packed from the highest field down; message flags are always zero.
    always_ff @(posedge clk)
    begin
        if (state_reg == rmst_pkg::BK_EXEC)
        begin
            out_reg <= {60'd0, recvs_n, sends_n, 7'(total), 8'd0,
                        (!ok ? 32'd0 :
                         (cmd_reg.op == rmst_pkg::OP_SEND) ? next_id_reg[rgn] :
                         ident_reg[place_reg]),
                        (do_recv ? rd_len_reg : 13'd0),
                        (ok ? place_reg[rmst_pkg::SPR_BITS-1:0] : 4'd0),
                        (ok ? rgn : 2'd0),
                        st};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmst_pkg::BK_IDLE;
            busy_reg  <= '0;
            sends_reg <= '0;
            recvs_reg <= '0;
            for (int k = 0; k < N; k++)
            begin
                src_reg[k]   <= '0;
                ident_reg[k] <= '0;
            end
            for (int r = 0; r < rmst_pkg::REGIONS; r++)
            begin
                next_id_reg[r] <= '0;
                free_reg[r]    <= rmst_pkg::FREE_BITS'(rmst_pkg::SLOTS_PER_REGION);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rmst_pkg::BK_EXEC)
            begin
                sends_reg <= sends_n;
                recvs_reg <= recvs_n;
                if (do_send)
                begin
                    busy_reg[place_reg]  <= 1'b1;
                    src_reg[place_reg]   <= cmd_reg.caller;
                    ident_reg[place_reg] <= next_id_reg[rgn];
                    next_id_reg[rgn]     <= next_id_reg[rgn] + 32'd1;
                    free_reg[rgn]        <= free_reg[rgn] - rmst_pkg::FREE_BITS'(1);
                end
                if (frees)
                begin
                    busy_reg[place_reg] <= 1'b0;
                    free_reg[rgn]       <= free_reg[rgn] + rmst_pkg::FREE_BITS'(1);
                end
            end
        end
    end
endmodule

// ----- src/rmst_checker.sv -----
// Port-level checker for the slot table, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rmst_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  logic [199:0]    m_axis_tdata
);
    `ASSERT_IMPL(a_flags_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[60:53] == 8'd0)
    `ASSERT_IMPL(a_free_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[67:61] <= 7'd64)
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0, m_axis_tdata[52:2] == 51'd0)
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind refcounted_message_slot_table rmst_checker u_rmst_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/rmst_checker.sv -----
// Checker for the message slot table: predicts each result word from the accepted
// input words and compares it field by field. Depends on rmst_pkg.
`timescale 1ns / 100ps
module rmst_scoreboard
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [87:0]  in_data,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [199:0] out_data,
    output int           fail_count,
    output int           pending
);
    // Declared from the highest field down so that status sits in the lowest bits.
    typedef struct packed {
        logic [63:0]        receives;
        logic [63:0]        sends;
        logic [6:0]         free_total;
        logic [7:0]         flags;
        logic [31:0]        id;
        logic [12:0]        size;
        logic [3:0]         slot;
        logic [1:0]         region;
        rmst_pkg::status_t  status;
    } result_t;

    logic        busy   [rmst_pkg::NSLOTS];
    logic [15:0] source [rmst_pkg::NSLOTS];
    logic [15:0] length [rmst_pkg::NSLOTS];
    logic [7:0]  refs   [rmst_pkg::NSLOTS];
    logic [31:0] ident  [rmst_pkg::NSLOTS];
    logic [31:0] next_ident [rmst_pkg::REGIONS];
    int          free_cnt [rmst_pkg::REGIONS];
    logic [63:0] sends_done, receives_done;
    result_t     expected_results [$];

    assign pending = expected_results.size();

    function automatic void drop_ref(input int k);
        if (refs[k] > 0) refs[k]--;
        if (refs[k] == 0)
        begin
            busy[k] = 1'b0;
            free_cnt[k / rmst_pkg::SLOTS_PER_REGION]++;
        end
    endfunction

    function automatic result_t predict_slot_op(input logic [87:0] d);
        rmst_pkg::op_t op;
        logic [15:0]   caller, peer, size;
        logic [31:0]   want;
        result_t       r;
        int            place, total, k;
        op = rmst_pkg::op_t'(d[1:0]);
        caller = d[17:2];
        peer = d[33:18];
        size = d[49:34];
        want = d[81:50];
        r = '0;
        r.status = rmst_pkg::ST_OK;
        place = -1;
        case (op)
            rmst_pkg::OP_SEND:
            begin
                if (size == 0 || size > rmst_pkg::BUF_BYTES)
                    r.status = rmst_pkg::ST_INVALID;
                else
                begin
                    for (k = 0; k < rmst_pkg::NSLOTS && place < 0; k++)
                        if (!busy[k]) place = k;
                    if (place < 0)
                        r.status = rmst_pkg::ST_NO_FREE;
                    else
                    begin
                        busy[place] = 1'b1;
                        source[place] = caller;
                        length[place] = size;
                        refs[place] = 8'd1;
                        ident[place] = next_ident[place / rmst_pkg::SLOTS_PER_REGION];
                        next_ident[place / rmst_pkg::SLOTS_PER_REGION]++;
                        free_cnt[place / rmst_pkg::SLOTS_PER_REGION]--;
                        sends_done++;
                        r.id = ident[place];
                    end
                end
            end
            rmst_pkg::OP_RECEIVE:
            begin
                for (k = 0; k < rmst_pkg::NSLOTS && place < 0; k++)
                    if (busy[k] && source[k] == peer) place = k;
                if (place < 0)
                    r.status = rmst_pkg::ST_NO_MSG;
                else
                begin
                    r.size = length[place][12:0];
                    r.id = ident[place];
                    drop_ref(place);
                    receives_done++;
                end
            end
            default:
            begin
                for (k = 0; k < rmst_pkg::NSLOTS && place < 0; k++)
                    if (ident[k] == want) place = k;
                if (place < 0)
                    r.status = rmst_pkg::ST_INVALID;
                else
                begin
                    r.id = want;
                    if (busy[place])
                    begin
                        if (op == rmst_pkg::OP_RELEASE) drop_ref(place);
                        else if (refs[place] < 8'd255) refs[place]++;
                    end
                end
            end
        endcase
        if (r.status == rmst_pkg::ST_OK)
        begin
            r.region = 2'(place / rmst_pkg::SLOTS_PER_REGION);
            r.slot = 4'(place % rmst_pkg::SLOTS_PER_REGION);
        end
        total = 0;
        for (k = 0; k < rmst_pkg::REGIONS; k++) total += free_cnt[k];
        r.free_total = 7'(total);
        r.sends = sends_done;
        r.receives = receives_done;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t e, a;
        if (!rst_n)
        begin
            for (int k = 0; k < rmst_pkg::NSLOTS; k++)
            begin
                busy[k] = 1'b0;
                source[k] = '0;
                length[k] = '0;
                refs[k] = '0;
                ident[k] = '0;
            end
            for (int k = 0; k < rmst_pkg::REGIONS; k++)
            begin
                next_ident[k] = '0;
                free_cnt[k] = rmst_pkg::SLOTS_PER_REGION;
            end
            sends_done = '0;
            receives_done = '0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_slot_op(in_data));
            if (out_valid && out_ready)
            begin
                a = out_data[195:0];
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (a.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, a.status);
                        fail_count++;
                    end
                    if (a.region !== e.region)
                    begin
                        $error("region_index: expected %0d, got %0d", e.region, a.region);
                        fail_count++;
                    end
                    if (a.slot !== e.slot)
                    begin
                        $error("slot_index: expected %0d, got %0d", e.slot, a.slot);
                        fail_count++;
                    end
                    if (a.size !== e.size)
                    begin
                        $error("size_out: expected %0d, got %0d", e.size, a.size);
                        fail_count++;
                    end
                    if (a.id !== e.id)
                    begin
                        $error("assigned_id: expected %0d, got %0d", e.id, a.id);
                        fail_count++;
                    end
                    if (a.flags !== e.flags)
                    begin
                        $error("message_flags: expected %0d, got %0d", e.flags, a.flags);
                        fail_count++;
                    end
                    if (a.free_total !== e.free_total)
                    begin
                        $error("free_total: expected %0d, got %0d",
                               e.free_total, a.free_total);
                        fail_count++;
                    end
                    if (a.sends !== e.sends)
                    begin
                        $error("send_count: expected %0d, got %0d", e.sends, a.sends);
                        fail_count++;
                    end
                    if (a.receives !== e.receives)
                    begin
                        $error("receive_count: expected %0d, got %0d",
                               e.receives, a.receives);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- test/tb_refcounted_message_slot_table.sv -----
// Top of the slot table testbench: clock, reset, stimulus and verdict.
// Depends on rmst_pkg, rmst_scoreboard and the block itself.
`timescale 1ns / 100ps
module tb_refcounted_message_slot_table;
    localparam int WATCHDOG_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    int           words_sent;
    logic [15:0]  used_threads [4];

    refcounted_message_slot_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rmst_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver runs in phases: always ready, random stalls, or long stalls.
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Nothing accepted for too long means the block is hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_word(input rmst_pkg::op_t op, input logic [15:0] caller,
                             input logic [15:0] peer, input logic [15:0] size,
                             input logic [31:0] id);
        s_axis_tdata <= {6'b0, id, size, peer, caller, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        words_sent++;
    endtask

    task automatic sender_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // Mostly sizes that are valid, with the edges and bad sizes now and then.
    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom_range(rmst_pkg::BUF_BYTES + 1, 65535));
            2: return 16'(rmst_pkg::BUF_BYTES);
            3: return 16'd1;
            default: return 16'($urandom_range(1, rmst_pkg::BUF_BYTES));
        endcase
    endfunction

    function automatic logic [15:0] pick_thread();
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
        return used_threads[$urandom_range(0, 3)];
    endfunction

    // Ids are mostly small since each region counts up from zero.
    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 40);
    endfunction

    initial
    begin
        rmst_pkg::op_t op;
        int            burst, weight;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        words_sent = 0;
        used_threads[0] = 16'h0000;
        used_threads[1] = 16'hFFFF;
        used_threads[2] = 16'h5A5A;
        used_threads[3] = 16'hA5A5;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: free-slot id match after reset, bad sizes, extremes.
        send_word(rmst_pkg::OP_RELEASE, 16'h0, 16'h0, 16'h0, 32'd0);
        send_word(rmst_pkg::OP_ADDREF, 16'h0, 16'h0, 16'h0, 32'd0);
        send_word(rmst_pkg::OP_RELEASE, 16'h0, 16'h0, 16'h0, 32'hFFFFFFFF);
        send_word(rmst_pkg::OP_SEND, 16'hFFFF, 16'h0, 16'd0, 32'h0);
        send_word(rmst_pkg::OP_SEND, 16'hFFFF, 16'h0, 16'd4097, 32'h0);
        send_word(rmst_pkg::OP_SEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
        send_word(rmst_pkg::OP_RECEIVE, 16'h0, 16'h1234, 16'h0, 32'h0);
        send_word(rmst_pkg::OP_SEND, 16'hFFFF, 16'h0, 16'd4096, 32'h0);
        send_word(rmst_pkg::OP_SEND, 16'h0000, 16'hFFFF, 16'd1, 32'h0);
        send_word(rmst_pkg::OP_ADDREF, 16'h0, 16'h0, 16'h0, 32'd0);
        send_word(rmst_pkg::OP_RECEIVE, 16'h0, 16'hFFFF, 16'h0, 32'h0);
        send_word(rmst_pkg::OP_RECEIVE, 16'h0, 16'hFFFF, 16'h0, 32'h0);
        send_word(rmst_pkg::OP_RECEIVE, 16'h0, 16'h0000, 16'h0, 32'h0);
        send_word(rmst_pkg::OP_RELEASE, 16'h0, 16'h0, 16'h0, 32'd1);
        // Saturate a count past 255, then drain it with releases.
        send_word(rmst_pkg::OP_SEND, 16'h0001, 16'h0, 16'd100, 32'h0);
        repeat (260) send_word(rmst_pkg::OP_ADDREF, 16'h0, 16'h0, 16'h0, 32'd2);
        repeat (256) send_word(rmst_pkg::OP_RELEASE, 16'h0, 16'h0, 16'h0, 32'd2);
        sender_gap();

        // Send more words than the table has slots to try to fill it, then hold off until drained.
        repeat (70) send_word(rmst_pkg::OP_SEND, 16'($urandom), 16'($urandom),
                              pick_size(), $urandom);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);

        // Random part in bursts, with phases that lean toward sends or toward the other ops.
        while (words_sent < 1800)
        begin
            weight = $urandom_range(20, 80);
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < weight) op = rmst_pkg::OP_SEND;
                else op = rmst_pkg::op_t'($urandom_range(1, 3));
                send_word(op, pick_thread(), pick_thread(), pick_size(), pick_id());
            end
            if ($urandom_range(0, 2) != 0) sender_gap();
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/rmst_pkg.sv
src/rmst_front.sv
src/rmst_back.sv
src/refcounted_message_slot_table.sv
src/rmst_checker.sv
test/rmst_checker.sv
test/tb_refcounted_message_slot_table.sv
